/* hw/rtl/blta_pkg.sv */
`default_nettype none

package blta_pkg;

  localparam int unsigned DimBitsDef   = 14;
  localparam int unsigned SliceBitsDef = 11;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned OffW = 32;
  localparam int unsigned BppW = 5;

  localparam int unsigned TileWShift = 6;
  localparam int unsigned TileHShift = 3;
  localparam int unsigned TileShift  = 9;

  localparam int unsigned OutDataW = ((2 * OffW + BppW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - 2 * OffW - BppW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDirection   = 4'd0,
    CfgBytesPerPix = 4'd1,
    CfgWidth       = 4'd2,
    CfgHeight      = 4'd3,
    CfgDepth       = 4'd4,
    CfgBlockHeight = 4'd5,
    CfgBlockDepth  = 4'd6,
    CfgStrideAlign = 4'd7
  } cfg_idx_e;

  localparam logic [CfgIdxW-1:0] CfgIdxMax = CfgStrideAlign;

  typedef struct packed {
    logic        direction;
    logic [4:0]  bytes_per_pixel;
    logic [14:0] width_pixels;
    logic [14:0] height_rows;
    logic [11:0] depth_slices;
    logic [2:0]  block_height_log2;
    logic [2:0]  block_depth_log2;
    logic [3:0]  stride_align_log2;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    direction:         1'b0,
    bytes_per_pixel:   5'd4,
    width_pixels:      15'd1,
    height_rows:       15'd1,
    depth_slices:      12'd1,
    block_height_log2: 3'd0,
    block_depth_log2:  3'd0,
    stride_align_log2: 4'd0
  };

endpackage

`default_nettype wire

/* hw/rtl/blta_pipe.sv */
`default_nettype none

module blta_pipe #(
  parameter int unsigned DIM_BITS   = blta_pkg::DimBitsDef,
  parameter int unsigned SLICE_BITS = blta_pkg::SliceBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire blta_pkg::cfg_t            cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [DIM_BITS-1:0]       column_i,
  input  wire logic [DIM_BITS-1:0]       row_i,
  input  wire logic [SLICE_BITS-1:0]     slice_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [blta_pkg::OffW-1:0]      source_offset_o,
  output logic [blta_pkg::OffW-1:0]      dest_offset_o,
  output logic [blta_pkg::BppW-1:0]      copy_bytes_o,
  output logic                           last_pixel_o
);

  localparam int unsigned XW      = DIM_BITS + blta_pkg::BppW;
  localparam int unsigned TYW     = DIM_BITS - blta_pkg::TileHShift;
  localparam int unsigned AlW     = 16;
  localparam int unsigned PitchW  = 20;
  localparam int unsigned StrideW = 21;
  localparam int unsigned TxW     = 16;
  localparam int unsigned RbW     = 16;
  localparam int unsigned OffW    = blta_pkg::OffW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: pitch, aligned stride and byte column.
  logic [AlW-1:0]        amask, aligned;
  logic [PitchW-1:0]     pitch_d1, pitch_q1;
  logic [StrideW-1:0]    stride_d1, stride_q1;
  logic [XW-1:0]         x_d1, x_q1;
  logic                  last_d1, last_q1;
  logic [DIM_BITS-1:0]   row_q1;
  logic [SLICE_BITS-1:0] slice_q1;

  always_comb begin
    amask     = (AlW'(1) << cfg_i.stride_align_log2) - AlW'(1);
    aligned   = (AlW'(cfg_i.width_pixels) + amask) & ~amask;
    pitch_d1  = PitchW'(cfg_i.width_pixels) * PitchW'(cfg_i.bytes_per_pixel);
    stride_d1 = StrideW'(aligned) * StrideW'(cfg_i.bytes_per_pixel);
    x_d1      = XW'(column_i) * XW'(cfg_i.bytes_per_pixel);
    last_d1   = (cfg_i.width_pixels != '0) && (cfg_i.height_rows != '0) &&
                (cfg_i.depth_slices != '0) &&
                (32'(column_i) == 32'(cfg_i.width_pixels) - 32'd1) &&
                (32'(row_i) == 32'(cfg_i.height_rows) - 32'd1) &&
                (32'(slice_i) == 32'(cfg_i.depth_slices) - 32'd1);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pitch_q1  <= pitch_d1;
      stride_q1 <= stride_d1;
      x_q1      <= x_d1;
      last_q1   <= last_d1;
      row_q1    <= row_i;
      slice_q1  <= slice_i;
    end
  end

  // Stage 2: block size, row blocks, pitch products and the column part.
  logic [TxW-1:0]        tiles_x;
  logic [4:0]            blk_sh, zl_sh;
  logic [3:0]            rows_sh;
  logic [SLICE_BITS-1:0] bd_mask;
  logic [8:0]            in_tile;
  logic [OffW-1:0]       block_size_d2, block_size_q2;
  logic [RbW-1:0]        rblk_d2, rblk_q2;
  logic [OffW-1:0]       slice_pitch_d2, slice_pitch_q2;
  logic [OffW-1:0]       row_pitch_d2, row_pitch_q2;
  logic [OffW-1:0]       xt_d2, xt_q2;
  logic [TYW-1:0]        tile_y_q2;
  logic [SLICE_BITS-1:0] slice_q2;
  logic [XW-1:0]         x_q2;
  logic                  last_q2;

  always_comb begin
    tiles_x  = TxW'((22'(stride_q1) + 22'd63) >> blta_pkg::TileWShift);
    blk_sh   = 5'(blta_pkg::TileShift) + 5'(cfg_i.block_height_log2)
             + 5'(cfg_i.block_depth_log2);
    zl_sh    = 5'(blta_pkg::TileShift) + 5'(cfg_i.block_height_log2);
    rows_sh  = 4'(blta_pkg::TileHShift) + 4'(cfg_i.block_height_log2);
    bd_mask  = (SLICE_BITS'(1) << cfg_i.block_depth_log2) - SLICE_BITS'(1);
    in_tile  = {x_q1[5], row_q1[2:1], x_q1[4], row_q1[0], x_q1[3:0]};
    block_size_d2  = OffW'(tiles_x) << blk_sh;
    rblk_d2        = (RbW'(cfg_i.height_rows) + ((RbW'(1) << rows_sh) - RbW'(1)))
                     >> rows_sh;
    slice_pitch_d2 = OffW'(slice_q1) * OffW'(pitch_q1);
    row_pitch_d2   = OffW'(row_q1) * OffW'(pitch_q1);
    xt_d2 = (OffW'(x_q1 >> blta_pkg::TileWShift) << blk_sh) + OffW'(in_tile)
          + (OffW'(slice_q1 & bd_mask) << zl_sh);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      block_size_q2  <= block_size_d2;
      rblk_q2        <= rblk_d2;
      slice_pitch_q2 <= slice_pitch_d2;
      row_pitch_q2   <= row_pitch_d2;
      xt_q2          <= xt_d2;
      tile_y_q2      <= row_q1[DIM_BITS-1:blta_pkg::TileHShift];
      slice_q2       <= slice_q1;
      x_q2           <= x_q1;
      last_q2        <= last_q1;
    end
  end

  // Stage 3: slice size, block row product and the linear slice term.
  logic [TYW-1:0]        bh_mask;
  logic [OffW-1:0]       slice_size_d3, slice_size_q3;
  logic [OffW-1:0]       off_y_d3, off_y_q3;
  logic [OffW-1:0]       xyl_d3, xyl_q3;
  logic [OffW-1:0]       sph_d3, sph_q3;
  logic [OffW-1:0]       row_pitch_q3;
  logic [SLICE_BITS-1:0] slice_q3;
  logic [XW-1:0]         x_q3;
  logic                  last_q3;

  always_comb begin
    bh_mask       = (TYW'(1) << cfg_i.block_height_log2) - TYW'(1);
    slice_size_d3 = OffW'(rblk_q2) * block_size_q2;
    off_y_d3      = OffW'(tile_y_q2 >> cfg_i.block_height_log2) * block_size_q2;
    xyl_d3        = xt_q2 + (OffW'(tile_y_q2 & bh_mask) << blta_pkg::TileShift);
    sph_d3        = slice_pitch_q2 * OffW'(cfg_i.height_rows);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      slice_size_q3 <= slice_size_d3;
      off_y_q3      <= off_y_d3;
      xyl_q3        <= xyl_d3;
      sph_q3        <= sph_d3;
      row_pitch_q3  <= row_pitch_q2;
      slice_q3      <= slice_q2;
      x_q3          <= x_q2;
      last_q3       <= last_q2;
    end
  end

  // Stage 4: slice block product and the linear offset.
  logic [OffW-1:0] off_z_d4, off_z_q4;
  logic [OffW-1:0] linear_d4, linear_q4;
  logic [OffW-1:0] off_y_q4, xyl_q4;
  logic            last_q4;

  always_comb begin
    off_z_d4  = OffW'(slice_q3 >> cfg_i.block_depth_log2) * slice_size_q3;
    linear_d4 = sph_q3 + row_pitch_q3 + OffW'(x_q3);
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      off_z_q4  <= off_z_d4;
      linear_q4 <= linear_d4;
      off_y_q4  <= off_y_q3;
      xyl_q4    <= xyl_q3;
      last_q4   <= last_q3;
    end
  end

  // Stage 5: tiled sum and the output register.
  logic [OffW-1:0]           tiled;
  logic [OffW-1:0]           src_d5, src_q5, dst_d5, dst_q5;
  logic [blta_pkg::BppW-1:0] bytes_q5;
  logic                      last_q5;

  always_comb begin
    tiled  = off_z_q4 + off_y_q4 + xyl_q4;
    src_d5 = cfg_i.direction ? linear_q4 : tiled;
    dst_d5 = cfg_i.direction ? tiled : linear_q4;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      src_q5   <= src_d5;
      dst_q5   <= dst_d5;
      bytes_q5 <= cfg_i.bytes_per_pixel;
      last_q5  <= last_q4;
    end
  end

  assign out_valid_o     = v5_q;
  assign source_offset_o = src_q5;
  assign dest_offset_o   = dst_q5;
  assign copy_bytes_o    = bytes_q5;
  assign last_pixel_o    = last_q5;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted transaction did not enter the first stage");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q && $stable(xt_q2) && $stable(block_size_q2))
    else $error("stalled stage lost or changed its data");
`endif

endmodule

`default_nettype wire

/* hw/rtl/block_linear_texture_address.sv */
// Block-linear texture address generator.
// Each input transaction on s_axis carries one pixel coordinate (column,
// row, slice); each output transaction on m_axis carries the byte offsets of
// that pixel in the tiled block-linear layout and in the pitch-linear layout,
// issued as source and destination according to the direction register,
// together with the copy size and a tlast flag on the final texture pixel.
// The configuration channel is always ready and must only be written while
// no transaction is in flight; it sets the texture geometry.
// One pixel is accepted per cycle while s_axis_tready is high, and each result
// passes through five register stages set by the chain of products
// (block size, then slice size, then the slice block offset).
// Reset empties the pipeline and loads the default geometry. When the
// receiver stalls, the full stages hold their data and s_axis_tready falls
// only once every stage is occupied, so no transaction is lost or repeated.

`default_nettype none

module block_linear_texture_address #(
  parameter int unsigned DIM_BITS   = blta_pkg::DimBitsDef,
  parameter int unsigned SLICE_BITS = blta_pkg::SliceBitsDef
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  wire logic [blta_pkg::CfgIdxW-1:0]               cfg_index_i,
  input  wire logic [blta_pkg::CfgDataW-1:0]              cfg_data_i,
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  // column, row, slice, zero padding
  input  wire logic [((2*DIM_BITS+SLICE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  // source_offset, dest_offset, copy_bytes, zero padding
  output logic [blta_pkg::OutDataW-1:0]                   m_axis_tdata,
  output logic                                            m_axis_tlast
);

  blta_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (blta_pkg::cfg_idx_e'(cfg_index_i))
        blta_pkg::CfgDirection:   cfg_d.direction         = cfg_data_i[0];
        blta_pkg::CfgBytesPerPix: cfg_d.bytes_per_pixel   = cfg_data_i[4:0];
        blta_pkg::CfgWidth:       cfg_d.width_pixels      = cfg_data_i[14:0];
        blta_pkg::CfgHeight:      cfg_d.height_rows       = cfg_data_i[14:0];
        blta_pkg::CfgDepth:       cfg_d.depth_slices      = cfg_data_i[11:0];
        blta_pkg::CfgBlockHeight: cfg_d.block_height_log2 = cfg_data_i[2:0];
        blta_pkg::CfgBlockDepth:  cfg_d.block_depth_log2  = cfg_data_i[2:0];
        blta_pkg::CfgStrideAlign: cfg_d.stride_align_log2 = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= blta_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic [blta_pkg::OffW-1:0] source_offset, dest_offset;
  logic [blta_pkg::BppW-1:0] copy_bytes;

  blta_pipe #(
    .DIM_BITS   (DIM_BITS),
    .SLICE_BITS (SLICE_BITS)
  ) u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .column_i        (s_axis_tdata[DIM_BITS-1:0]),
    .row_i           (s_axis_tdata[2*DIM_BITS-1:DIM_BITS]),
    .slice_i         (s_axis_tdata[2*DIM_BITS+SLICE_BITS-1:2*DIM_BITS]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .source_offset_o (source_offset),
    .dest_offset_o   (dest_offset),
    .copy_bytes_o    (copy_bytes),
    .last_pixel_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{blta_pkg::OutPadW{1'b0}}, copy_bytes, dest_offset, source_offset};

`ifndef NO_ASSERTIONS
  a_cfg_unknown_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i > blta_pkg::CfgIdxMax) |=> $stable(cfg_q))
    else $error("write to an unknown register index changed the configuration");
`endif

endmodule

`default_nettype wire
